/* hdl/positional_list_insert_delete_defines.svh */
// Assertion macros for the checker file of the positional list.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/plid_pkg.sv */
package plid_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int LEN_W        = 8;
    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [POS_W-1:0]  pos_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic  ins;
        logic  del;
        pos_t  k;
        data_t value;
    } plid_cmd_t;

endpackage

/* hdl/plid_if.sv */
interface plid_req_if;
    import plid_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    pos_t        position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value,
                    input ready);
    modport sink   (input valid, input action, input position, input value,
                    output ready);
endinterface

interface plid_rsp_if;
    import plid_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [DATA_W-1:0] value_out;
    logic [LEN_W-1:0] length;

    modport source (output valid, output status, output value_out, output length,
                    input ready);
    modport sink   (input valid, input status, input value_out, input length,
                    output ready);
endinterface

/* hdl/positional_list_insert_delete.sv */
// Channel | Dir | Fields                      | Handshake
// req     | in  | action, position, value     | valid / ready
// rsp     | out | status, value_out, length   | valid / ready
//
// One request is taken per cycle, unless a response waits and rsp.ready is low;
// its response appears in the output register the cycle after, and the whole
// cell chain shifts in the same cycle as the output register is loaded.
// req.ready is low only while a response waits and rsp.ready is low.
// rst_n clears the element count and the output valid flag; the cells keep
// whatever they hold, which is never read before it is written.
module positional_list_insert_delete #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    plid_req_if.sink  req,
    plid_rsp_if.source rsp
);
    import plid_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    logic [1:0]       status_reg;
    data_t            value_out_reg;
    logic [LEN_W-1:0] length_reg;

    logic             accept;
    logic [1:0]       status;
    logic             do_ins;
    logic             do_del;
    logic             take_value;
    pos_t             k;
    logic [POS_W:0]   pos_x;
    logic [POS_W:0]   cnt_x;
    plid_cmd_t        cmd;
    data_t            rd_value;

    data_t cell_data [CAPACITY];
    data_t rd_part   [CAPACITY];

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_x = {1'b0, req.position};
    assign cnt_x = (POS_W + 1)'(count_reg);

    always_comb
    begin
        status     = ST_OK;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        take_value = 1'b0;
        k          = req.position - POS_W'(1);
        unique case (req.action) inside
            ACT_INSERT:
            begin
                if (req.position == '0 || pos_x > cnt_x + (POS_W + 1)'(1))
                    status = ST_BADPOS;
                else if (count_reg == CAP_CNT)
                    status = ST_FULL;
                else
                    do_ins = 1'b1;
            end
            ACT_POP:
            begin
                k = '0;
                if (count_reg == '0)
                    status = ST_EMPTY;
                else
                begin
                    do_del     = 1'b1;
                    take_value = 1'b1;
                end
            end
            ACT_DELETE, ACT_READ:
            begin
                if (count_reg == '0)
                    status = ST_EMPTY;
                else if (req.position == '0 || pos_x > cnt_x)
                    status = ST_BADPOS;
                else
                begin
                    do_del     = (req.action == ACT_DELETE);
                    take_value = 1'b1;
                end
            end
            default:
            begin
                status = ST_BADPOS;
            end
        endcase
    end

    assign cmd.ins   = accept && do_ins;
    assign cmd.del   = accept && do_del;
    assign cmd.k     = k;
    assign cmd.value = req.value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            data_t left_d;
            data_t right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = req.value;
            end
            else
            begin : g_left
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[gi];
            end
            else
            begin : g_right
                assign right_d = cell_data[gi+1];
            end

            plid_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .rd_data    (rd_part[gi])
            );
        end
    endgenerate

    // Only the cell whose index matches k drives a nonzero read word.
    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_value = rd_value | rd_part[i];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.del)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status;
            value_out_reg <= take_value ? rd_value : '0;
            length_reg    <= LEN_W'(count_next);
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.length    = length_reg;

endmodule

/* hdl/plid_cell.sv */
module plid_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  plid_pkg::plid_cmd_t cmd,
    input  plid_pkg::data_t     left_data,
    input  plid_pkg::data_t     right_data,
    output plid_pkg::data_t     data,
    output plid_pkg::data_t     rd_data
);
    import plid_pkg::*;

    localparam pos_t IDX = POS_W'(INDEX);

    data_t data_reg;
    data_t data_next;

    // An insert moves every word behind the insertion point one cell back;
    // a delete pulls every word from the deleted cell on one cell forward.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (IDX == cmd.k)
                data_next = cmd.value;
            else if (IDX > cmd.k)
                data_next = left_data;
        end
        else if (cmd.del)
        begin
            if (IDX >= cmd.k)
                data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = (IDX == cmd.k) ? data_reg : '0;

endmodule

/* hdl/plid_checker.sv */
`include "positional_list_insert_delete_defines.svh"

module plid_checker #(
    parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [1:0]               status,
    input logic [plid_pkg::DATA_W-1:0] value_out,
    input logic [plid_pkg::LEN_W-1:0]  length
);
    import plid_pkg::*;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // A waiting response keeps its word until it is taken.
    `PLID_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(value_out) && $stable(length), "response changed while stalled")

    // Every accepted request shows its response in the next cycle.
    `PLID_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid, "no response after an accepted request")

    // A failed request returns a zero word.
    `PLID_ASSERT_NOW(a_fail_zero, rsp_valid && status != ST_OK, value_out == '0, "nonzero word on a failed request")

    // A full refusal only happens at capacity, and an empty one only at zero length.
    `PLID_ASSERT_NOW(a_full_len, rsp_valid && status == ST_FULL, length == CAP_LEN, "full status below capacity")

    `PLID_ASSERT_NOW(a_empty_len, rsp_valid && status == ST_EMPTY, length == '0, "empty status with elements held")

endmodule

bind positional_list_insert_delete plid_checker #(
    .CAPACITY (CAPACITY)
) u_plid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .value_out (rsp.value_out),
    .length    (rsp.length)
);

/* tb/sv/tb_positional_list_insert_delete.sv */
`timescale 1ns / 100ps

module tb_positional_list_insert_delete;
    import plid_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 650;
    localparam int STALL_CYCLES = 40;

    typedef struct {
        logic [1:0] action;
        pos_t       position;
        data_t      value;
    } list_req_t;

    typedef struct {
        logic [1:0]       status;
        data_t            value_out;
        logic [LEN_W-1:0] length;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    plid_req_if req ();
    plid_rsp_if rsp ();

    positional_list_insert_delete #(
        .CAPACITY (CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    list_req_t pending_reqs[$];
    list_rsp_t expected_rsp[$];

    // Shadow copy of the list contents, updated on every accepted request.
    data_t            model_entries [CAP];
    logic [LEN_W-1:0] model_count = '0;

    // Element count as the stimulus generator sees it, used to aim positions.
    int gen_count = 0;

    int  send_gap = 0;
    int  recv_gap = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    logic rsp_hold;

    int req_accepted = 0;
    int rsp_checked = 0;
    int fail_count = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int peak_length = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        foreach (model_entries[i])
            model_entries[i] = '0;
    end

    function automatic list_rsp_t apply_list_op(input list_req_t r);
        list_rsp_t o;
        int n;
        int k;
        int i;
        n = int'(model_count);
        o.status = ST_OK;
        o.value_out = '0;
        case (r.action)
            ACT_INSERT:
            begin
                if (r.position == 0 || r.position > n + 1)
                    o.status = ST_BADPOS;
                else if (n >= CAP)
                    o.status = ST_FULL;
                else
                begin
                    k = r.position - 1;
                    for (i = n; i > k; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[k] = r.value;
                    model_count = LEN_W'(n + 1);
                end
            end
            ACT_POP:
            begin
                if (n == 0)
                    o.status = ST_EMPTY;
                else
                begin
                    o.value_out = model_entries[0];
                    for (i = 0; i < n - 1; i++)
                        model_entries[i] = model_entries[i+1];
                    model_count = LEN_W'(n - 1);
                end
            end
            default:
            begin
                if (n == 0)
                    o.status = ST_EMPTY;
                else if (r.position == 0 || r.position > n)
                    o.status = ST_BADPOS;
                else
                begin
                    k = r.position - 1;
                    o.value_out = model_entries[k];
                    if (r.action == ACT_DELETE)
                    begin
                        for (i = k; i < n - 1; i++)
                            model_entries[i] = model_entries[i+1];
                        model_count = LEN_W'(n - 1);
                    end
                end
            end
        endcase
        o.length = model_count;
        return o;
    endfunction

    // Queues one request and follows its effect on the element count.
    task automatic queue_item(input logic [1:0] act, input int pos, input data_t val);
        list_req_t r;
        r.action = act;
        r.position = pos_t'(pos);
        r.value = val;
        pending_reqs.push_back(r);
        case (act)
            ACT_INSERT:
                if (pos >= 1 && pos <= gen_count + 1 && gen_count < CAP)
                    gen_count++;
            ACT_POP:
                if (gen_count > 0)
                    gen_count--;
            ACT_DELETE:
                if (gen_count > 0 && pos >= 1 && pos <= gen_count)
                    gen_count--;
            default:
                ;
        endcase
    endtask

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 24) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Mostly positions inside the valid range, with the ends favored.
    function automatic int pick_position(input int top);
        int r;
        r = $urandom_range(0, 19);
        if (top == 0 || r < 2)
            return $urandom_range(0, 255);
        if (r == 2)
            return top + 1;
        if (r == 3)
            return 1;
        if (r == 4)
            return top;
        return $urandom_range(1, top);
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        bit growing;
        int r;
        logic [1:0] act;

        rst_n = 1'b0;
        req.valid = 1'b0;
        req.action = ACT_INSERT;
        req.position = '0;
        req.value = '0;
        rsp.ready = 1'b0;

        // Empty list: every removal or read reports empty.
        queue_item(ACT_READ, 1, $urandom);
        queue_item(ACT_DELETE, 0, $urandom);
        queue_item(ACT_POP, 1, $urandom);
        queue_item(ACT_READ, 255, $urandom);
        // Insert positions outside 1..count+1.
        queue_item(ACT_INSERT, 0, 32'h1234_5678);
        queue_item(ACT_INSERT, 2, 32'h1234_5678);
        queue_item(ACT_INSERT, 255, 32'h1234_5678);
        // Build a short list at the front, back and middle.
        queue_item(ACT_INSERT, 1, 32'h8000_0000);
        queue_item(ACT_INSERT, 2, 32'h7fff_ffff);
        queue_item(ACT_INSERT, 1, 32'hffff_ffff);
        queue_item(ACT_INSERT, 4, 32'h0000_0000);
        queue_item(ACT_INSERT, 3, 32'h5555_5555);
        queue_item(ACT_INSERT, 7, 32'haaaa_aaaa);
        // Reads and deletes at and beyond the ends.
        queue_item(ACT_READ, 0, $urandom);
        queue_item(ACT_READ, 6, $urandom);
        queue_item(ACT_READ, 5, $urandom);
        queue_item(ACT_READ, 1, $urandom);
        queue_item(ACT_DELETE, 255, $urandom);
        queue_item(ACT_DELETE, 6, $urandom);
        queue_item(ACT_DELETE, 3, $urandom);
        queue_item(ACT_DELETE, 4, $urandom);
        queue_item(ACT_POP, 0, $urandom);
        queue_item(ACT_DELETE, 1, $urandom);
        queue_item(ACT_POP, 200, $urandom);
        queue_item(ACT_POP, 1, $urandom);

        // The random part alternates between filling the list up to full and
        // draining it back to empty, so both boundaries are crossed repeatedly.
        growing = 1'b1;
        repeat (RANDOM_ITEMS)
        begin
            if (growing && gen_count == CAP && $urandom_range(0, 4) == 0)
                growing = 1'b0;
            else if (!growing && gen_count == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 99) == 0)
                growing = ~growing;

            r = $urandom_range(0, 19);
            if (r == 0)
                act = 2'($urandom_range(0, 3));
            else if (growing)
                act = (r < 16) ? ACT_INSERT : (r < 17) ? ACT_DELETE :
                      (r < 18) ? ACT_POP : ACT_READ;
            else
                act = (r < 4) ? ACT_INSERT : (r < 10) ? ACT_DELETE :
                      (r < 14) ? ACT_POP : ACT_READ;

            if (act == ACT_INSERT)
                queue_item(act, pick_position(gen_count + 1), pick_value());
            else
                queue_item(act, pick_position(gen_count), $urandom);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req.valid)
            @(posedge clk);
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Checked %0d responses: %0d ok, %0d bad position, %0d empty, %0d full.",
                 rsp_checked, status_seen[ST_OK], status_seen[ST_BADPOS],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("Longest list held %0d of %0d entries; %0d mismatches.",
                 peak_length, CAP, fail_count);
        if (fail_count == 0 && expected_rsp.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Long output stalls while requests keep coming, to back the block up.
    initial
    begin
        int milestones [2];
        rsp_hold = 1'b0;
        milestones = '{150, 420};
        foreach (milestones[m])
        begin
            while (req_accepted < milestones[m])
                @(posedge clk);
            rsp_hold <= 1'b1;
            repeat (STALL_CYCLES) @(posedge clk);
            rsp_hold <= 1'b0;
        end
    end

    initial
    begin
        #200000;
        $display("Timeout with %0d responses still outstanding.", expected_rsp.size());
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        list_req_t nxt;
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!req.valid || req.ready)
        begin
            if (send_gap > 0)
            begin
                req.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() != 0)
            begin
                nxt = pending_reqs.pop_front();
                req.valid <= 1'b1;
                req.action <= nxt.action;
                req.position <= nxt.position;
                req.value <= nxt.value;
                send_gap <= draw_gap(send_calm);
            end
            else
                req.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_gap <= 0;
        end
        else if (rsp_hold)
            rsp.ready <= 1'b0;
        else if (rsp.valid && rsp.ready)
        begin
            g = draw_gap(recv_calm);
            recv_gap <= g;
            rsp.ready <= (g == 0);
        end
        else if (recv_gap > 1)
        begin
            recv_gap <= recv_gap - 1;
            rsp.ready <= 1'b0;
        end
        else
        begin
            recv_gap <= 0;
            rsp.ready <= 1'b1;
        end
    end

    // Requests are predicted before responses are checked in the same cycle,
    // so a response can never be compared against a stale queue.
    always @(posedge clk)
    begin
        list_req_t r;
        list_rsp_t got;
        list_rsp_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                r.action = req.action;
                r.position = req.position;
                r.value = req.value;
                expected_rsp.push_back(apply_list_op(r));
                req_accepted++;
            end
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.value_out = rsp.value_out;
                got.length = rsp.length;
                rsp_checked++;
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Response with nothing expected: ",
                                 "status %0d value %h length %0d",
                                 got.status, got.value_out, got.length);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.status !== want.status || got.value_out !== want.value_out ||
                        got.length !== want.length)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch on response %0d: ", rsp_checked,
                                     "expected status %0d value %h length %0d, ",
                                     want.status, want.value_out, want.length,
                                     "got status %0d value %h length %0d",
                                     got.status, got.value_out, got.length);
                    end
                    status_seen[want.status]++;
                    if (int'(want.length) > peak_length)
                        peak_length = int'(want.length);
                end
            end
        end
    end

endmodule
